[sv/bvm_pkg.sv]
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared constants for the battery voltage monitor: register indexes,
// register reset values, level codes and output buffer sizing.
// ----------------------------------------------------------------------------
package bvm_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 10;     // width of the count registers
    localparam int CNT_LIMIT  = 1024;   // one past the largest count value
    localparam int TIME_W     = 16;
    localparam int NOW_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOOD     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP  = 4'd3;

    // Register reset values (ADC counts and milliseconds)
    localparam int SHUTDOWN_RST = 784;
    localparam int GOOD_RST     = 906;
    localparam int BAD_RST      = 797;
    localparam logic [TIME_W-1:0] STARTUP_RST = 16'd2600;

    // Battery level codes
    localparam int LEVEL_W = 2;
    localparam logic [LEVEL_W-1:0] LEVEL_GOOD = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WARN = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_BAD  = 2'd2;

    // Result buffer
    localparam int FIFO_DEPTH = 8;
    localparam int INFLIGHT_W = $clog2(FIFO_DEPTH + 4);

endpackage

[sv/bvm_sample_ring.sv]
// ----------------------------------------------------------------------------
// bvm_sample_ring
// Sample ring memory: one write port, one registered read port, and a
// clearing sweep that zeroes one entry per cycle after reset or on request.
// ----------------------------------------------------------------------------
module bvm_sample_ring #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear_start,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     busy
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] ring_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             busy_reg;
    logic [AW-1:0]    sweep_idx_reg;

    // Sweep control: reset starts a full pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b1;
            sweep_idx_reg <= '0;
        end else if (busy_reg) begin
            if (sweep_idx_reg == AW'(DEPTH - 1)) begin
                busy_reg      <= 1'b0;
                sweep_idx_reg <= '0;
            end else begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
        end else if (clear_start) begin
            busy_reg      <= 1'b1;
            sweep_idx_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            ring_mem[sweep_idx_reg] <= '0;
        end else if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

[sv/bvm_out_fifo.sv]
// ----------------------------------------------------------------------------
// bvm_out_fifo
// Small result buffer that decouples the fixed pipeline from the output
// channel; reports its fill level so the input side can reserve space.
// ----------------------------------------------------------------------------
module bvm_out_fifo #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_mem [DEPTH];
    logic [PW-1:0]    head_reg, tail_reg;
    logic [CW-1:0]    count_reg;
    logic             pop;

    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                tail_reg <= (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop) begin
                head_reg <= (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[tail_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = buf_mem[head_reg];
    assign count     = count_reg;

endmodule

[sv/battery_voltage_monitor.sv]
// ----------------------------------------------------------------------------
// battery_voltage_monitor: moving-average supervisor with power enable.
// Beats pass stage 1, stage 2, the product register and result buffer; one beat per
// cycle sustained while the buffer has room and no ring clear holds s_tready low.
// Synchronous reset or a shutdown starts a ring clear sweep, holding s_tready low.
// ----------------------------------------------------------------------------
module battery_voltage_monitor #(
    parameter int RING_DEPTH  = 128,
    parameter int DECIMATION  = 2,
    parameter int SAMPLE_BITS = 10
) (
    input  logic aclk,
    input  logic aresetn,

    // Input beats
    input  logic s_tvalid,
    output logic s_tready,
    // battery_sample [SAMPLE_BITS-1:0], now_ms [SAMPLE_BITS+31:SAMPLE_BITS], zero pad
    input  logic [((SAMPLE_BITS + bvm_pkg::NOW_W + 7) / 8) * 8 - 1:0] s_tdata,

    // Result beats
    output logic m_tvalid,
    input  logic m_tready,
    // mean_count [SAMPLE_BITS-1:0], power_on [SAMPLE_BITS],
    // level [SAMPLE_BITS+2:SAMPLE_BITS+1], zero pad
    output logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata,

    // Register writes
    input  logic                           cfg_wr_en,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bvm_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int M_DATA_W = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
    localparam int OUT_W    = SAMPLE_BITS + 1 + LEVEL_W;
    localparam int LOG_D    = $clog2(RING_DEPTH);
    localparam int SUM_W    = $clog2(RING_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int THR_W    = $clog2(CNT_LIMIT * RING_DEPTH + 1);
    localparam int CMP_W    = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int PHASE_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    // floor(sum / RING_DEPTH) = (sum * RECIP) >> SHIFT, exact for every sum
    localparam int SHIFT    = SUM_W + LOG_D;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);

    // Count thresholds scaled into the sum domain:
    //   mean >  T  <=>  sum >= (T + 1) * RING_DEPTH
    //   mean >= T  <=>  sum >=  T      * RING_DEPTH
    localparam logic [THR_W-1:0] SHUT_THR_RST = THR_W'((SHUTDOWN_RST + 1) * RING_DEPTH);
    localparam logic [THR_W-1:0] GOOD_THR_RST = THR_W'((GOOD_RST + 1) * RING_DEPTH);
    localparam logic [THR_W-1:0] BAD_THR_RST  = THR_W'(BAD_RST * RING_DEPTH);

    // ------------------------------------------------------------------
    // Configuration: store thresholds pre-scaled so the hot path compares
    // the running sum directly (no divide in the decision loop).
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  shut_thr_reg, good_thr_reg, bad_thr_reg;
    logic [TIME_W-1:0] startup_reg;
    logic [CNT_W-1:0]  wr_cnt;
    logic [THR_W-1:0]  wr_thr, wr_thr_plus1;

    assign wr_cnt       = cfg_wdata[CNT_W-1:0];
    assign wr_thr       = THR_W'(wr_cnt) * THR_W'(RING_DEPTH);
    assign wr_thr_plus1 = THR_W'({1'b0, wr_cnt} + {{CNT_W{1'b0}}, 1'b1}) * THR_W'(RING_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shut_thr_reg <= SHUT_THR_RST;
            good_thr_reg <= GOOD_THR_RST;
            bad_thr_reg  <= BAD_THR_RST;
            startup_reg  <= STARTUP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SHUTDOWN: shut_thr_reg <= wr_thr_plus1;
                CFG_GOOD:     good_thr_reg <= wr_thr_plus1;
                CFG_BAD:      bad_thr_reg  <= wr_thr;
                CFG_STARTUP:  startup_reg  <= cfg_wdata[TIME_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: decimate, claim a ring slot and start its read.
    // The ring read is issued at the write pointer on every edge, so the
    // accepted item finds the old entry of its slot in the next cycle.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [NOW_W-1:0]       in_now;
    logic                   accept;
    logic                   is_store;
    logic [PHASE_W-1:0]     phase_reg;
    logic [LOG_D-1:0]       wp_reg;

    assign in_sample = s_tdata[SAMPLE_BITS-1:0];
    assign in_now    = s_tdata[SAMPLE_BITS +: NOW_W];
    assign accept    = s_tvalid && s_tready;
    assign is_store  = (phase_reg == PHASE_W'(DECIMATION - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            wp_reg    <= '0;
        end else if (accept) begin
            phase_reg <= is_store ? '0 : phase_reg + 1'b1;
            if (is_store) begin
                wp_reg <= (wp_reg == LOG_D'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    // Stage 1 holding registers
    logic                   s1_valid_reg;
    logic                   s1_store_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [LOG_D-1:0]       s1_slot_reg;
    logic                   s1_late_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_store_reg  <= is_store;
            s1_sample_reg <= in_sample;
            s1_slot_reg   <= wp_reg;
            s1_late_reg   <= (in_now > NOW_W'(startup_reg));
        end
    end

    // ------------------------------------------------------------------
    // Sample ring
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] ring_old;
    logic                   ring_busy;
    logic                   clear_now;

    bvm_sample_ring #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear_start (clear_now),
        .wr_en       (s1_valid_reg && s1_store_reg),
        .wr_addr     (s1_slot_reg),
        .wr_data     (s1_sample_reg),
        .rd_addr     (wp_reg),
        .rd_data     (ring_old),
        .busy        (ring_busy)
    );

    // ------------------------------------------------------------------
    // Stage 1: update the running sum, decide power and level.
    // Sum, power and ring write commit here, so back-to-back items chain
    // through sum_reg with no hazard.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]   sum_reg;
    logic               power_reg;
    logic [SUM_W-1:0]   new_sum;
    logic [CMP_W-1:0]   sum_cmp;
    logic               above_shut, above_good, above_bad;
    logic               power_next;
    logic [LEVEL_W-1:0] level_next;

    assign new_sum = s1_store_reg
                   ? (sum_reg - SUM_W'(ring_old) + SUM_W'(s1_sample_reg))
                   : sum_reg;
    assign sum_cmp    = CMP_W'(new_sum);
    assign above_shut = (sum_cmp >= CMP_W'(shut_thr_reg));
    assign above_good = (sum_cmp >= CMP_W'(good_thr_reg));
    assign above_bad  = (sum_cmp >= CMP_W'(bad_thr_reg));

    // Power turns on only past startup with the mean above shutdown; a drop
    // to or below shutdown while on clears the whole ring.
    assign power_next = s1_late_reg && above_shut;
    assign clear_now  = s1_valid_reg && power_reg && !above_shut;

    always_comb begin
        if (above_good) begin
            level_next = LEVEL_GOOD;
        end else if (above_bad) begin
            level_next = LEVEL_WARN;
        end else begin
            level_next = LEVEL_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            power_reg <= 1'b0;
        end else if (s1_valid_reg) begin
            sum_reg   <= clear_now ? '0 : new_sum;
            power_reg <= power_next;
        end
    end

    // Stage 2: hold the sum seen by this item (before any clear)
    logic               s2_valid_reg;
    logic [SUM_W-1:0]   s2_sum_reg;
    logic               s2_power_reg;
    logic [LEVEL_W-1:0] s2_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_sum_reg   <= new_sum;
            s2_power_reg <= power_next;
            s2_level_reg <= level_next;
        end
    end

    // Stage 3: reciprocal multiply for the mean
    logic               p_valid_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               p_power_reg;
    logic [LEVEL_W-1:0] p_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            prod_reg    <= PROD_W'(s2_sum_reg) * PROD_W'(RECIP);
            p_power_reg <= s2_power_reg;
            p_level_reg <= s2_level_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer. The pipeline after the accept stage never stalls, so
    // the input side reserves a buffer slot for every beat in flight.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0]                  fifo_in, fifo_out;
    logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_count;
    logic [INFLIGHT_W-1:0]             occupancy;
    logic                              room;

    assign fifo_in = {p_level_reg, p_power_reg, prod_reg[SHIFT +: SAMPLE_BITS]};

    bvm_out_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p_valid_reg),
        .push_data (fifo_in),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_tdata = M_DATA_W'(fifo_out);

    assign occupancy = INFLIGHT_W'(fifo_count)
                     + INFLIGHT_W'(s1_valid_reg)
                     + INFLIGHT_W'(s2_valid_reg)
                     + INFLIGHT_W'(p_valid_reg);
    assign room      = (occupancy < INFLIGHT_W'(FIFO_DEPTH));

    // Hold input during a ring sweep and in the cycle a clear is decided,
    // so no item reads an entry that is about to be zeroed.
    assign s_tready = room && !ring_busy && !clear_now;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // The buffer must never be pushed while full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> (fifo_count < ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH)
                         || (m_tvalid && m_tready)))
        else $error("result buffer overflow");

    // A clear empties the sum and starts the ring sweep on the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_now |=> (ring_busy && sum_reg == '0 && !power_reg))
        else $error("clear did not take effect");

    // Nothing enters stage 1 while the ring is being swept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ring_busy |=> !s1_valid_reg || $past(!ring_busy))
        else $error("item accepted during ring sweep");

    // Results carry one of the three level codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (fifo_out[OUT_W-1 -: LEVEL_W] == LEVEL_GOOD
                      || fifo_out[OUT_W-1 -: LEVEL_W] == LEVEL_WARN
                      || fifo_out[OUT_W-1 -: LEVEL_W] == LEVEL_BAD))
        else $error("invalid level code");

endmodule

[dv/bvm_checker.sv]
// ----------------------------------------------------------------------------
// bvm_checker
// Watches the input, result and register-write ports of the battery voltage
// monitor, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module bvm_checker #(
    parameter int RING_DEPTH  = 128,
    parameter int DECIMATION  = 2,
    parameter int SAMPLE_BITS = 10,
    parameter int S_W         = 48,
    parameter int M_W         = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [S_W-1:0]                 s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [M_W-1:0]                 m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bvm_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(RING_DEPTH);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean;
        logic                   power;
        logic [LEVEL_W-1:0]     level;
    } supervisor_out_t;

    // Mirror of the block's state and registers
    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    logic [SUM_W-1:0]       ring_sum;
    int                     wr_ptr;
    int                     dec_phase;
    logic                   powered;
    logic [CNT_W-1:0]       shut_th;
    logic [CNT_W-1:0]       good_th;
    logic [CNT_W-1:0]       bad_th;
    logic [TIME_W-1:0]      start_th;

    supervisor_out_t        awaited_q[$];
    supervisor_out_t        want;
    supervisor_out_t        got;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic supervisor_out_t step_supervisor(
        input logic [SAMPLE_BITS-1:0] sample,
        input logic [NOW_W-1:0]       now
    );
        supervisor_out_t r;
        logic [SAMPLE_BITS-1:0] mean;
        dec_phase = dec_phase + 1;
        if (dec_phase >= DECIMATION) begin
            dec_phase = 0;
            ring_sum = ring_sum - ring[wr_ptr] + sample;
            ring[wr_ptr] = sample;
            wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
        end
        mean = SAMPLE_BITS'(ring_sum / RING_DEPTH);

        if (now > start_th && mean > shut_th) begin
            powered = 1'b1;
        end else if (mean <= shut_th && powered) begin
            // shutdown while on wipes the whole ring, pointer and phase stay
            for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
            ring_sum = '0;
            powered = 1'b0;
        end else begin
            powered = 1'b0;
        end

        r.mean  = mean;
        r.power = powered;
        if (mean > good_th)
            r.level = LEVEL_GOOD;
        else if (mean >= bad_th)
            r.level = LEVEL_WARN;
        else
            r.level = LEVEL_BAD;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
            ring_sum  = '0;
            wr_ptr    = 0;
            dec_phase = 0;
            powered   = 1'b0;
            shut_th   = CNT_W'(SHUTDOWN_RST);
            good_th   = CNT_W'(GOOD_RST);
            bad_th    = CNT_W'(BAD_RST);
            start_th  = STARTUP_RST;
            awaited_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SHUTDOWN: shut_th  = cfg_wdata[CNT_W-1:0];
                    CFG_GOOD:     good_th  = cfg_wdata[CNT_W-1:0];
                    CFG_BAD:      bad_th   = cfg_wdata[CNT_W-1:0];
                    CFG_STARTUP:  start_th = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.mean  = m_tdata[SAMPLE_BITS-1:0];
                got.power = m_tdata[SAMPLE_BITS];
                got.level = m_tdata[SAMPLE_BITS+2:SAMPLE_BITS+1];
                if (awaited_q.size() == 0) begin
                    $error("result beat with nothing awaited: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    if (got.mean !== want.mean) begin
                        $error("mean_count: expected %0d, actual %0d", want.mean, got.mean);
                        fail_count++;
                    end
                    if (got.power !== want.power) begin
                        $error("power_on: expected %0d, actual %0d", want.power, got.power);
                        fail_count++;
                    end
                    if (got.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, got.level);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                awaited_q.push_back(step_supervisor(s_tdata[SAMPLE_BITS-1:0],
                                                    s_tdata[SAMPLE_BITS+NOW_W-1:SAMPLE_BITS]));
        end
        pending_count = awaited_q.size();
    end

endmodule

[dv/tb_battery_voltage_monitor.sv]
// ----------------------------------------------------------------------------
// tb_battery_voltage_monitor
// Drives sensor events into the battery voltage monitor through several
// threshold settings, with random gaps on both stream ports, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_battery_voltage_monitor;
    timeunit 1ns;
    timeprecision 1ps;
    import bvm_pkg::*;

    localparam int RING_DEPTH   = 128;
    localparam int DECIMATION   = 2;
    localparam int SAMPLE_BITS  = 10;
    localparam int S_W          = ((SAMPLE_BITS + NOW_W + 7) / 8) * 8;
    localparam int M_W          = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int CNT_MAX      = CNT_LIMIT - 1;
    localparam int TIME_MAX     = (1 << TIME_W) - 1;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_BEATS  = 105;
    localparam int DRAIN_CYCLES = 16;       // settling time after the results drain
    localparam int IDLE_LIMIT   = 4000;     // covers the ring clear sweep and long gaps

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // battery_sample [9:0], now_ms [41:10], zero pad [47:42]
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // mean_count [9:0], power_on [10], level [12:11], zero pad [15:13]
    logic [M_W-1:0]        m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending_count;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;         // no gaps on either side while set
    int clock_ms    = 0;            // running millisecond time fed to the block
    int cur_startup = 2600;

    always #6 aclk = ~aclk;

    battery_voltage_monitor #(
        .RING_DEPTH (RING_DEPTH),
        .DECIMATION (DECIMATION),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    bvm_checker #(
        .RING_DEPTH (RING_DEPTH),
        .DECIMATION (DECIMATION),
        .SAMPLE_BITS(SAMPLE_BITS),
        .S_W        (S_W),
        .M_W        (M_W)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Result side: stall m_tready at random; no new stall starts while calm
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    // Watchdog: any beat on either stream port resets the idle count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one event and hold it until the block takes the beat
    task automatic send_beat(input int sample, input logic [NOW_W-1:0] now);
        logic [S_W-1:0] beat;
        beat = '0;
        beat[SAMPLE_BITS-1:0] = SAMPLE_BITS'(sample);
        beat[SAMPLE_BITS+NOW_W-1:SAMPLE_BITS] = now;
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop s_tvalid for a random gap after a beat; keep it high on a zero gap
    task automatic pace_sender();
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drain all results, let the pipeline settle, and wait for the input to open
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Write all four thresholds, junk in the unused upper bits, plus an
    // out-of-range index that the block must ignore
    task automatic load_thresholds(input int shut, input int good, input int bad, input int start);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        w[CNT_W-1:0] = CNT_W'(shut);
        write_reg(CFG_SHUTDOWN, w);
        w = CFG_DATA_W'($urandom());
        w[CNT_W-1:0] = CNT_W'(good);
        write_reg(CFG_GOOD, w);
        w = CFG_DATA_W'($urandom());
        w[CNT_W-1:0] = CNT_W'(bad);
        write_reg(CFG_BAD, w);
        write_reg(CFG_STARTUP, CFG_DATA_W'(start));
        write_reg(CFG_IDX_W'($urandom_range(CFG_STARTUP + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom()));
        cfg_wr_en <= 1'b0;
        cur_startup = start;
    endtask

    function automatic logic [NOW_W-1:0] next_now();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return $urandom();
        else if (r == 1)
            return NOW_W'(cur_startup);
        else if (r == 2)
            return NOW_W'(cur_startup + 1);
        clock_ms += $urandom_range(0, 25);
        return NOW_W'(clock_ms);
    endfunction

    initial begin
        int sent;
        int burst;
        int target;
        int sample;
        int shut;
        int good;
        int bad;
        int start;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults after reset: field extremes and the startup boundary
        send_beat(0, '0);
        send_beat(SAMPLE_MAX, '1);
        send_beat(SAMPLE_MAX, NOW_W'(2600));
        send_beat(SAMPLE_MAX, NOW_W'(2601));
        send_beat(0, NOW_W'(2601));
        send_beat(SAMPLE_MAX, NOW_W'(2601));

        // Low thresholds: rise through bad, warn and good; hold power off
        // until the startup time has passed, then drop it with an early time
        wait_idle();
        load_thresholds(20, 40, 30, 100);
        repeat (6) send_beat(SAMPLE_MAX, NOW_W'(100));
        repeat (4) send_beat(SAMPLE_MAX, NOW_W'(101));
        send_beat(SAMPLE_MAX, NOW_W'(50));
        send_beat(0, NOW_W'(200));
        send_beat(SAMPLE_MAX, NOW_W'(200));

        // Raise the shutdown level above the mean while power is on: clear
        wait_idle();
        load_thresholds(CNT_MAX, 40, 30, 100);
        send_beat(512, NOW_W'(300));
        send_beat(512, NOW_W'(300));
        send_beat(SAMPLE_MAX, NOW_W'(300));

        // Random phases, each with its own threshold set
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            if (p == 0) begin
                load_thresholds(0, 0, 0, 0);
            end else if (p == 1) begin
                load_thresholds(CNT_MAX, CNT_MAX, CNT_MAX, TIME_MAX);
            end else begin
                shut  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CNT_MAX)
                                                    : $urandom_range(0, 120);
                good  = $urandom_range(0, 200);
                bad   = $urandom_range(0, 200);     // may land above good
                case ($urandom_range(0, 2))
                    0: start = 0;
                    1: start = (clock_ms + $urandom_range(0, 300)) & TIME_MAX;
                    default: start = $urandom_range(0, TIME_MAX);
                endcase
                load_thresholds(shut, good, bad, start);
            end
            calm = ($urandom_range(0, 3) == 0);

            // Bursts around one level so the mean actually moves
            sent = 0;
            while (sent < PHASE_BEATS) begin
                burst = $urandom_range(4, 40);
                case ($urandom_range(0, 3))
                    0: target = SAMPLE_MAX;
                    1: target = 0;
                    2: target = $urandom_range(0, SAMPLE_MAX);
                    default: target = SAMPLE_MAX / 2;
                endcase
                for (int k = 0; k < burst && sent < PHASE_BEATS; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        sample = $urandom_range(0, SAMPLE_MAX);
                    end else begin
                        sample = target + $urandom_range(0, 16) - 8;
                        if (sample < 0) sample = 0;
                        if (sample > SAMPLE_MAX) sample = SAMPLE_MAX;
                    end
                    send_beat(sample, next_now());
                    pace_sender();
                    sent++;
                end
            end
        end

        // Drain and give the verdict
        s_tvalid <= 1'b0;
        calm = 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
